### rtl/core/pbsc_pkg.sv
// ----------------------------------------------------------------------------
// pbsc_pkg - shared types and constants for the posting block structure check
// Item layouts, status and format codes, adaptive tag values.
// ----------------------------------------------------------------------------
`default_nettype none

package pbsc_pkg;

  localparam int BLOCK_SIZE_DEF = 256;

  localparam int BYTE_W   = 8;
  localparam int COUNT_W  = 10;
  localparam int STATUS_W = 4;
  localparam int TOTAL_W  = 11;
  localparam int FMT_W    = 2;

  // block_format register codes
  localparam logic [FMT_W-1:0] FMT_ADAPTIVE = 2'd0;
  localparam logic [FMT_W-1:0] FMT_LEGACY   = 2'd1;
  localparam logic [FMT_W-1:0] FMT_FIXED    = 2'd2;
  localparam logic [FMT_W-1:0] FMT_UNKNOWN  = 2'd3;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK          = 4'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_COUNT   = 4'd1;
  localparam logic [STATUS_W-1:0] ST_UNK_FORMAT  = 4'd2;
  localparam logic [STATUS_W-1:0] ST_TRUNC_HDR   = 4'd3;
  localparam logic [STATUS_W-1:0] ST_TRUNC_PAY   = 4'd4;
  localparam logic [STATUS_W-1:0] ST_TRUNC_CTL   = 4'd5;
  localparam logic [STATUS_W-1:0] ST_BAD_TAG     = 4'd6;
  localparam logic [STATUS_W-1:0] ST_VINT_OVF    = 4'd7;
  localparam logic [STATUS_W-1:0] ST_BAD_EXC_POS = 4'd8;
  localparam logic [STATUS_W-1:0] ST_PATCH_OVF   = 4'd9;
  localparam logic [STATUS_W-1:0] ST_TRAILING    = 4'd10;
  localparam logic [STATUS_W-1:0] ST_BOUND       = 4'd11;

  // adaptive tag values
  localparam logic [BYTE_W-1:0] TAG_BITPACK_MAX = 8'd32;
  localparam logic [BYTE_W-1:0] TAG_CONST_MIN   = 8'd33;
  localparam logic [BYTE_W-1:0] TAG_CONST_MAX   = 8'd35;
  localparam logic [BYTE_W-1:0] TAG_SVB         = 8'd36;
  localparam logic [BYTE_W-1:0] TAG_PFOR        = 8'd37;

  localparam int VINT_LAST_GROUP = 4;

  typedef struct packed {
    logic [BYTE_W-1:0]  data_byte;
    logic [COUNT_W-1:0] block_count;
    logic               last;
    logic               no_data;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [TOTAL_W-1:0]  byte_total;
  } out_item_t;

  // StreamVByte payload length of one 2-bit control code
  function automatic logic [2:0] code_len(input logic [1:0] code);
    logic [2:0] len;
    case (code)
      2'd0:    len = 3'd0;
      2'd1:    len = 3'd1;
      2'd2:    len = 3'd2;
      default: len = 3'd4;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

### rtl/core/posting_block_structure_check_unit.sv
// One block byte is taken per transfer and a new item can be accepted every
// cycle while input is not stalled: each item sits in the input register,
// where the parse step for that byte runs, and the verdict of a block's last
// item is then registered into the output register. No result is made for
// other items. A finished result waiting on out_ready stalls input only when
// the item in the input register is itself a last item.
// ----------------------------------------------------------------------------
// posting_block_structure_check_unit - compressed posting block validator
// Walks fixed StreamVByte and adaptive (bit-pack, constant, StreamVByte,
// patched FOR) block layouts byte by byte and reports the first error.
// ----------------------------------------------------------------------------
`default_nettype none

module posting_block_structure_check_unit
  import pbsc_pkg::*;
#(
  parameter int BLOCK_SIZE = BLOCK_SIZE_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_item_t    in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_item_t        out_data,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int BOUND    = 1 + (BLOCK_SIZE + 3) / 4 + 4 * BLOCK_SIZE;
  localparam int SAT      = (BOUND + 1 > 2047) ? BOUND + 1 : 2047;
  localparam int CNT_W    = $clog2(SAT + 1);
  localparam int SKIP_MAX = (4 * BLOCK_SIZE > 255) ? 4 * BLOCK_SIZE : 255;
  localparam int SKIP_W   = $clog2(SKIP_MAX + 1);
  localparam int CTL_W    = $clog2((BLOCK_SIZE + 3) / 4 + 1);
  localparam int LPOS_W   = BYTE_W + 1;

  localparam logic [COUNT_W:0]  BS_L      = (COUNT_W + 1)'(BLOCK_SIZE);
  localparam logic [CNT_W-1:0]  SAT_L     = CNT_W'(SAT);
  localparam logic [CNT_W-1:0]  BOUND_L   = CNT_W'(BOUND);
  localparam logic [CNT_W-1:0]  TOT_MAX_L = CNT_W'(2047);

  typedef enum logic [3:0] {
    PH_START,
    PH_TAG,
    PH_TOKEN,
    PH_VINT,
    PH_POS,
    PH_PATCH,
    PH_CONTROLS,
    PH_SKIP,
    PH_DONE
  } phase_t;

  // configuration
  logic [FMT_W-1:0] block_format_r;

  // input register
  logic     s1_valid_r;
  in_item_t s1_r;
  logic     s1_go;

  // block state
  phase_t              phase_r, phase_nxt;
  logic [CNT_W-1:0]    bytes_r, bytes_nxt;
  logic [SKIP_W-1:0]   skip_r, skip_nxt;
  logic [4:0]          bw_r, bw_nxt;
  logic [2:0]          exc_r, exc_nxt;
  logic [LPOS_W-1:0]   lpos_r, lpos_nxt;
  logic [2:0]          vg_r, vg_nxt;
  logic [CTL_W-1:0]    ctl_r, ctl_nxt;
  logic [SKIP_W-1:0]   psum_r, psum_nxt;
  logic [STATUS_W-1:0] ferr_r, ferr_nxt;
  logic [COUNT_W-1:0]  held_r, held_nxt;

  // output register
  logic      out_valid_r;
  out_item_t out_r, out_nxt;

  // parse step temporaries
  logic [BYTE_W-1:0]   b;
  logic [5:0]          mul_op;
  logic [15:0]         prod;
  logic [16:0]         prod_rnd;
  logic                do_skip;
  logic [SKIP_W-1:0]   skip_n;
  logic [COUNT_W:0]    ctl_init;
  logic [2:0]          fields;
  logic [4:0]          ctl_sum;
  logic [BYTE_W-1:0]   pos;
  logic [39:0]         patch_sh;
  logic [STATUS_W-1:0] st;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {{(32 - FMT_W){1'b0}}, block_format_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_format_r <= FMT_ADAPTIVE;
    end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
      block_format_r <= pwdata[FMT_W-1:0];
    end
  end

  // a last item needs the output slot free (or freeing) to move on
  assign s1_go    = s1_valid_r && (!s1_r.last || !out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_go;

  assign b        = s1_r.data_byte;
  assign mul_op   = (phase_nxt == PH_TAG) ? b[5:0] : {1'b0, b[4:0]};

  always_comb begin
    // block start: sample the count, pick the entry phase
    if (phase_r == PH_START) begin
      held_nxt = s1_r.block_count;
      bytes_nxt = '0;
      skip_nxt = '0;
      bw_nxt = '0;
      exc_nxt = '0;
      lpos_nxt = '0;
      vg_nxt = '0;
      psum_nxt = '0;
      ferr_nxt = ST_OK;
      if (held_nxt == '0 || {1'b0, held_nxt} > BS_L) begin
        ferr_nxt = ST_BAD_COUNT;
      end else if (block_format_r == FMT_UNKNOWN) begin
        ferr_nxt = ST_UNK_FORMAT;
      end
      ctl_init = ({1'b0, held_nxt} + (COUNT_W + 1)'(3)) >> 2;
      if (block_format_r == FMT_FIXED) begin
        ctl_nxt = CTL_W'(ctl_init);
        phase_nxt = PH_CONTROLS;
      end else begin
        ctl_nxt = '0;
        phase_nxt = PH_TAG;
      end
    end else begin
      held_nxt = held_r;
      bytes_nxt = bytes_r;
      skip_nxt = skip_r;
      bw_nxt = bw_r;
      exc_nxt = exc_r;
      lpos_nxt = lpos_r;
      vg_nxt = vg_r;
      psum_nxt = psum_r;
      ferr_nxt = ferr_r;
      ctl_nxt = ctl_r;
      phase_nxt = phase_r;
      ctl_init = '0;
    end
  end

  assign prod     = 16'(held_nxt * mul_op);
  assign prod_rnd = {1'b0, prod} + 17'd7;
  assign pos      = skip_nxt[BYTE_W-1:0];
  assign patch_sh = {32'd0, b} << bw_nxt;

  // parse one byte
  phase_t              ph_c;
  logic [CNT_W-1:0]    bytes_c;
  logic [SKIP_W-1:0]   skip_c;
  logic [4:0]          bw_c;
  logic [2:0]          exc_c;
  logic [LPOS_W-1:0]   lpos_c;
  logic [2:0]          vg_c;
  logic [CTL_W-1:0]    ctl_c;
  logic [SKIP_W-1:0]   psum_c;
  logic [STATUS_W-1:0] ferr_c;

  always_comb begin
    ph_c = phase_nxt;
    bytes_c = bytes_nxt;
    skip_c = skip_nxt;
    bw_c = bw_nxt;
    exc_c = exc_nxt;
    lpos_c = lpos_nxt;
    vg_c = vg_nxt;
    ctl_c = ctl_nxt;
    psum_c = psum_nxt;
    ferr_c = ferr_nxt;
    do_skip = 1'b0;
    skip_n = '0;
    fields = 3'd4;
    ctl_sum = '0;
    if (!s1_r.no_data) begin
      if (bytes_nxt < SAT_L) begin
        bytes_c = bytes_nxt + CNT_W'(1);
      end
      if (ferr_nxt == ST_OK) begin
        unique case (phase_nxt)
          PH_TAG: begin
            if (b <= TAG_BITPACK_MAX) begin
              do_skip = 1'b1;
              skip_n = SKIP_W'(prod_rnd >> 3);
            end else if (b <= TAG_CONST_MAX) begin
              do_skip = 1'b1;
              skip_n = SKIP_W'(3'd1 << (b[1:0] - TAG_CONST_MIN[1:0]));
            end else if (b == TAG_SVB) begin
              ctl_c = CTL_W'(({1'b0, held_nxt} + (COUNT_W + 1)'(3)) >> 2);
              psum_c = '0;
              ph_c = PH_CONTROLS;
            end else if (b == TAG_PFOR) begin
              ph_c = PH_TOKEN;
            end else begin
              ferr_c = ST_BAD_TAG;
            end
          end
          PH_TOKEN: begin
            bw_c = b[4:0];
            exc_c = b[7:5];
            lpos_c = '0;
            if (b[4:0] != 5'd0) begin
              do_skip = 1'b1;
              skip_n = SKIP_W'(prod_rnd >> 3);
            end else begin
              vg_c = '0;
              ph_c = PH_VINT;
            end
          end
          PH_VINT: begin
            if (vg_nxt >= 3'(VINT_LAST_GROUP) && b[7:4] != 4'd0) begin
              ferr_c = ST_VINT_OVF;
            end else if (!b[7]) begin
              do_skip = 1'b1;
            end else begin
              vg_c = vg_nxt + 3'd1;
            end
          end
          PH_POS: begin
            skip_c = SKIP_W'(b);
            ph_c = PH_PATCH;
          end
          PH_PATCH: begin
            if (!({2'b00, pos} < held_nxt && {1'b0, pos} >= lpos_nxt)) begin
              ferr_c = ST_BAD_EXC_POS;
            end else if (b == '0 || patch_sh[39:32] != 8'd0) begin
              ferr_c = ST_PATCH_OVF;
            end else begin
              lpos_c = {1'b0, pos} + LPOS_W'(1);
              exc_c = exc_nxt - 3'd1;
              do_skip = 1'b1;
            end
          end
          PH_CONTROLS: begin
            // final control byte may hold fewer than four codes
            if (ctl_nxt == CTL_W'(1)) begin
              fields = {1'b0, held_nxt[1:0] - 2'd1} + 3'd1;
            end
            for (int i = 0; i < 4; i++) begin
              if (3'(i) < fields) begin
                ctl_sum = ctl_sum + {2'b00, code_len(b[2*i +: 2])};
              end
            end
            psum_c = psum_nxt + SKIP_W'(ctl_sum);
            ctl_c = ctl_nxt - CTL_W'(1);
            if (ctl_c == '0) begin
              do_skip = 1'b1;
              skip_n = psum_c;
            end
          end
          PH_SKIP: begin
            skip_c = skip_nxt - SKIP_W'(1);
            if (skip_c == '0) begin
              do_skip = 1'b1;
            end
          end
          default: begin
            ferr_c = ST_TRAILING;
          end
        endcase
        if (do_skip) begin
          if (skip_n == '0) begin
            ph_c = (exc_c != 3'd0) ? PH_POS : PH_DONE;
          end else begin
            skip_c = skip_n;
            ph_c = PH_SKIP;
          end
        end
      end
    end

    // verdict on the last item
    st = ferr_c;
    if (st == ST_OK) begin
      if (ph_c == PH_CONTROLS) begin
        st = ST_TRUNC_CTL;
      end else if (ph_c == PH_SKIP) begin
        st = ST_TRUNC_PAY;
      end else if (ph_c != PH_DONE) begin
        st = ST_TRUNC_HDR;
      end else if (bytes_c > BOUND_L) begin
        st = ST_BOUND;
      end
    end
    out_nxt.status = st;
    out_nxt.byte_total = TOTAL_W'((bytes_c > TOT_MAX_L) ? TOT_MAX_L : bytes_c);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      phase_r <= PH_START;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (in_ready && in_valid) begin
        s1_r <= in_data;
      end
      if (s1_go) begin
        phase_r <= s1_r.last ? PH_START : ph_c;
        bytes_r <= bytes_c;
        skip_r <= skip_c;
        bw_r <= bw_c;
        exc_r <= exc_c;
        lpos_r <= lpos_c;
        vg_r <= vg_c;
        ctl_r <= ctl_c;
        psum_r <= psum_c;
        ferr_r <= ferr_c;
        held_r <= held_nxt;
      end
      if (s1_go && s1_r.last) begin
        out_valid_r <= 1'b1;
        out_r <= out_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef NO_ASSERTIONS
  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && s1_r.last) |=> out_valid_r)
    else $error("last item did not produce a result");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.status <= ST_BOUND))
    else $error("status code out of range");

  a_first_error_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != PH_START && ferr_r != ST_OK) |=> (ferr_r == $past(ferr_r)))
    else $error("latched error changed inside a block");

  a_skip_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_SKIP) |-> (skip_r != '0))
    else $error("skip phase with nothing left to skip");

  a_vint_groups: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_VINT) |-> (vg_r <= 3'(VINT_LAST_GROUP)))
    else $error("base vint longer than five bytes");
`endif

endmodule

`default_nettype wire

### bench/posting_block_structure_check_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// posting_block_structure_check_unit_tb - self-checking bench for the block validator
// Streams well-formed, damaged and noise posting blocks in all four formats
// through the byte channel with random idling on both sides. A cycle-free
// parser in a scoreboard predicts each block verdict for comparison.
// ----------------------------------------------------------------------------

module posting_block_structure_check_unit_tb;
  import pbsc_pkg::*;

  localparam int BLK         = BLOCK_SIZE_DEF;
  localparam int BOUND       = 1 + (BLK + 3) / 4 + 4 * BLK;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE      = 8;
  localparam logic [2:0] REG_BLOCK_FORMAT = 3'd0;

  typedef enum logic [3:0] {
    PS_START, PS_TAG, PS_TOKEN, PS_VINT, PS_POS, PS_PATCH, PS_CTRL, PS_SKIP, PS_DONE
  } parse_state_t;

  // Predicts the verdict of each block from the bytes seen on the input channel.
  class block_verdict_board_t;
    logic [FMT_W-1:0]    fmt       = FMT_ADAPTIVE;
    parse_state_t        st        = PS_START;
    logic [15:0]         seen      = '0;
    logic [10:0]         skip_left = '0;
    logic [4:0]          bits      = '0;
    logic [2:0]          exc_left  = '0;
    logic [9:0]          next_pos  = '0;  // previous exception position + 1, 0 = none
    logic [2:0]          vint_len  = '0;
    logic [8:0]          ctl_left  = '0;
    logic [10:0]         pay_sum   = '0;
    logic [STATUS_W-1:0] err       = ST_OK;
    logic [COUNT_W-1:0]  count     = '0;
    out_item_t           verdicts[$];
    int                  fails     = 0;

    function void flag(string msg);
      fails++;
      if (fails <= 10) $display("%0t mismatch: %s", $time, msg);
    endfunction

    function void after_skip();
      st = (exc_left != 0) ? PS_POS : PS_DONE;
    endfunction

    function void start_skip(int unsigned n);
      if (n == 0) begin
        after_skip();
      end else begin
        skip_left = 11'(n);
        st = PS_SKIP;
      end
    endfunction

    function void start_ctl();
      ctl_left = 9'((32'(count) + 3) / 4);
      pay_sum = '0;
      st = PS_CTRL;
    endfunction

    function void parse_byte(logic [7:0] b);
      int unsigned fields, pos;
      logic [1:0] code;
      case (st)
        PS_TAG: begin
          if (b <= TAG_BITPACK_MAX) start_skip((32'(count) * 32'(b) + 7) / 8);
          else if (b <= TAG_CONST_MAX) start_skip(32'd1 << (b - TAG_CONST_MIN));
          else if (b == TAG_SVB) start_ctl();
          else if (b == TAG_PFOR) st = PS_TOKEN;
          else err = ST_BAD_TAG;
        end
        PS_TOKEN: begin
          bits = b[4:0];
          exc_left = b[7:5];
          next_pos = '0;
          if (bits != 0) begin
            start_skip((32'(count) * 32'(bits) + 7) / 8);
          end else begin
            vint_len = '0;
            st = PS_VINT;
          end
        end
        PS_VINT: begin
          if (vint_len >= VINT_LAST_GROUP && b[7:4] != 4'd0) err = ST_VINT_OVF;
          else if (!b[7]) after_skip();
          else vint_len = vint_len + 3'd1;
        end
        PS_POS: begin
          skip_left = {3'b000, b};
          st = PS_PATCH;
        end
        PS_PATCH: begin
          pos = skip_left;
          if (!(pos < count && pos + 1 > next_pos)) begin
            err = ST_BAD_EXC_POS;
          end else if (b == 0 || (64'(b) << bits) > 64'hFFFF_FFFF) begin
            err = ST_PATCH_OVF;
          end else begin
            next_pos = 10'(pos + 1);
            exc_left = exc_left - 3'd1;
            st = (exc_left != 0) ? PS_POS : PS_DONE;
          end
        end
        PS_CTRL: begin
          // only the first ((count - 1) mod 4) + 1 codes of the final control byte carry lengths
          fields = (ctl_left == 9'd1) ? ((32'(count) - 1) % 4) + 1 : 4;
          for (int i = 0; i < fields; i++) begin
            code = b[2*i +: 2];
            pay_sum = pay_sum + ((code == 2'd3) ? 11'd4 : 11'(code));
          end
          ctl_left = ctl_left - 9'd1;
          if (ctl_left == 0) start_skip(pay_sum);
        end
        PS_SKIP: begin
          skip_left = skip_left - 11'd1;
          if (skip_left == 0) after_skip();
        end
        default: err = ST_TRAILING;
      endcase
    endfunction

    function void note_transfer(in_item_t it);
      logic [STATUS_W-1:0] s;
      out_item_t v;
      if (st == PS_START) begin
        count = it.block_count;
        seen = '0;
        skip_left = '0;
        bits = '0;
        exc_left = '0;
        next_pos = '0;
        vint_len = '0;
        ctl_left = '0;
        pay_sum = '0;
        err = ST_OK;
        if (count == 0 || count > BLK) err = ST_BAD_COUNT;
        else if (fmt == FMT_UNKNOWN) err = ST_UNK_FORMAT;
        if (fmt == FMT_FIXED) start_ctl();
        else st = PS_TAG;
      end
      if (!it.no_data) begin
        if (seen != 16'hFFFF) seen = seen + 16'd1;
        if (err == ST_OK) parse_byte(it.data_byte);
      end
      if (it.last) begin
        s = err;
        if (s == ST_OK) begin
          if (st == PS_CTRL) s = ST_TRUNC_CTL;
          else if (st == PS_SKIP) s = ST_TRUNC_PAY;
          else if (st != PS_DONE) s = ST_TRUNC_HDR;
          else if (seen > BOUND) s = ST_BOUND;
        end
        v.status = s;
        v.byte_total = (seen > 16'd2047) ? 11'd2047 : seen[10:0];
        verdicts.insert(verdicts.size(), v);
        st = PS_START;
      end
    endfunction

    function void check_verdict(out_item_t got);
      out_item_t want;
      if (verdicts.size() == 0) begin
        flag($sformatf("unexpected result status %0d byte_total %0d",
                       got.status, got.byte_total));
      end else begin
        want = verdicts.pop_front();
        if (got.status != want.status)
          flag($sformatf("status expected %0d, got %0d", want.status, got.status));
        if (got.byte_total != want.byte_total)
          flag($sformatf("byte_total expected %0d, got %0d",
                         want.byte_total, got.byte_total));
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  block_verdict_board_t sb = new();

  logic [7:0] blk_bytes[$];
  int         sent_bytes;
  int         big_left;
  bit         idle_on;
  bit         junk_on;
  bit         hold_req;

  logic [FMT_W-1:0] fmt_plan [8] = '{FMT_FIXED, FMT_ADAPTIVE, FMT_LEGACY, FMT_UNKNOWN,
                                     FMT_FIXED, FMT_LEGACY, FMT_ADAPTIVE, FMT_FIXED};

  posting_block_structure_check_unit #(.BLOCK_SIZE(BLK)) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_transfer(in_data);
      if (out_valid && out_ready) sb.check_verdict(out_data);
    end
  end

  // result side: random stall bursts, plus one long hold-off on request
  initial begin
    int stall;
    out_ready = 1'b0;
    stall = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      if (stall > 0) begin
        out_ready = 1'b0;
        stall--;
      end else if (idle_on && $urandom_range(0, 99) < 12) begin
        out_ready = 1'b0;
        stall = $urandom_range(0, 13);
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  initial begin
    #5_000_000;
    $display("posting_block_structure_check_unit_tb NOT OK");
    $finish;
  end

  // Entered and left at a falling edge; valid stays up after the transfer so
  // that a back-to-back item only changes the payload.
  task automatic push_item(input in_item_t it);
    if (idle_on && $urandom_range(0, 99) < 15) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Sends blk_bytes as one block; the first item carries the count.
  task automatic send_block(input logic [COUNT_W-1:0] cnt);
    in_item_t it;
    bit first, tail;
    int n;
    first = 1'b1;
    n = blk_bytes.size();
    tail = junk_on && $urandom_range(0, 19) == 0;
    sent_bytes += (n == 0) ? 1 : n;
    for (int i = 0; i < n; i++) begin
      if (junk_on && $urandom_range(0, 19) == 0) begin
        it.data_byte = 8'($urandom);
        it.block_count = first ? cnt : 10'($urandom);
        it.last = 1'b0;
        it.no_data = 1'b1;
        push_item(it);
        first = 1'b0;
      end
      it.data_byte = blk_bytes[i];
      it.block_count = first ? cnt : 10'($urandom);
      it.last = (i == n - 1) && !tail;
      it.no_data = 1'b0;
      push_item(it);
      first = 1'b0;
    end
    if (n == 0 || tail) begin
      it.data_byte = 8'($urandom);
      it.block_count = first ? cnt : 10'($urandom);
      it.last = 1'b1;
      it.no_data = 1'b1;
      push_item(it);
    end
  endtask

  function automatic void put_byte(logic [7:0] b);
    blk_bytes.insert(blk_bytes.size(), b);
  endfunction

  function automatic void add_noise(int n);
    for (int i = 0; i < n; i++) put_byte(8'($urandom));
  endfunction

  function automatic void add_svb(int cnt);
    int nctl, sum, f;
    logic [7:0] b;
    nctl = (cnt + 3) / 4;
    sum = 0;
    for (int i = 0; i < nctl; i++) begin
      b = 8'($urandom);
      f = (i == nctl - 1) ? ((cnt - 1) % 4) + 1 : 4;
      for (int k = 0; k < f; k++) sum += (b[2*k +: 2] == 2'd3) ? 4 : int'(b[2*k +: 2]);
      put_byte(b);
    end
    add_noise(sum);
  endfunction

  function automatic void add_pfor(int cnt);
    int bits, exc, nv, p, hi, maxp;
    logic [7:0] b;
    bits = $urandom_range(0, 1) ? 0 : $urandom_range(1, 31);
    exc = $urandom_range(0, 7);
    if (exc > cnt && $urandom_range(0, 9) != 0) exc = cnt;
    put_byte(TAG_PFOR);
    put_byte(8'(exc * 32 + bits));
    if (bits != 0) begin
      add_noise((cnt * bits + 7) / 8);
    end else begin
      nv = $urandom_range(1, 5);
      for (int j = 0; j < nv; j++) begin
        b = 8'($urandom_range(0, 127));
        if (j < nv - 1) b[7] = 1'b1;
        else if (j == 4 && $urandom_range(0, 7) != 0) b[6:4] = 3'd0;
        put_byte(b);
      end
    end
    // rising positions while exc <= cnt; patches fit in 32 bits after the shift
    p = -1;
    for (int k = 0; k < exc; k++) begin
      if (exc <= cnt) begin
        hi = cnt - (exc - k);
        p = $urandom_range(p + 1, hi);
      end else begin
        p = $urandom_range(0, 255);
      end
      put_byte(8'(p));
      maxp = (bits > 24) ? (1 << (32 - bits)) - 1 : 255;
      b = 8'($urandom_range(1, maxp));
      if ($urandom_range(0, 29) == 0) b = 8'd0;
      put_byte(b);
    end
  endfunction

  function automatic void add_adaptive(int cnt);
    int r, tag;
    r = $urandom_range(0, 9);
    if (r < 3) begin
      tag = $urandom_range(0, 32);
      put_byte(8'(tag));
      add_noise((cnt * tag + 7) / 8);
    end else if (r == 3) begin
      tag = $urandom_range(33, 35);
      put_byte(8'(tag));
      add_noise(1 << (tag - 33));
    end else if (r < 6) begin
      put_byte(TAG_SVB);
      add_svb(cnt);
    end else if (r < 9) begin
      add_pfor(cnt);
    end else begin
      put_byte(8'($urandom_range(38, 255)));
      add_noise($urandom_range(0, 3));
    end
  endfunction

  task automatic send_random_block(input logic [FMT_W-1:0] fmt);
    int r, cnt, n;
    blk_bytes.delete();
    r = $urandom_range(0, 99);
    if (r < 80) begin
      cnt = $urandom_range(1, 16);
    end else if (r < 90) begin
      cnt = $urandom_range(17, 64);
    end else if (r < 94 && big_left > 0) begin
      big_left--;
      cnt = (r == 93) ? BLK : $urandom_range(65, BLK);
    end else if (r < 97) begin
      cnt = 0;
    end else begin
      cnt = $urandom_range(BLK + 1, 1023);
    end
    if (cnt == 0 || cnt > BLK) begin
      add_noise($urandom_range(0, 8));
    end else begin
      if (fmt == FMT_FIXED) add_svb(cnt);
      else add_adaptive(cnt);
      n = blk_bytes.size();
      r = $urandom_range(0, 99);
      if (r >= 72 && r < 80) begin
        repeat ($urandom_range(1, (n > 3) ? 3 : n)) void'(blk_bytes.pop_back());
      end else if (r >= 80 && r < 88) begin
        add_noise($urandom_range(1, 3));
      end else if (r >= 88 && r < 95) begin
        blk_bytes[$urandom_range(0, n - 1)] = 8'($urandom);
      end else if (r >= 95) begin
        blk_bytes.delete();
        add_noise($urandom_range(0, 12));
      end
    end
    send_block(10'(cnt));
  endtask

  task automatic set_format(input logic [FMT_W-1:0] fmt);
    logic [31:0] rd;
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = REG_BLOCK_FORMAT;
    pwdata = 32'(fmt);
    @(negedge clk) penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    sb.fmt = fmt;
    penable = 1'b0;
    pwrite = 1'b0;
    @(negedge clk) penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rd = prdata;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    if (rd != 32'(fmt))
      sb.flag($sformatf("block_format readback expected %0d, got %0d", fmt, rd));
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (sb.verdicts.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  initial begin
    int budget;
    bit paused;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    idle_on = 1'b0;
    junk_on = 1'b0;
    hold_req = 1'b0;
    sent_bytes = 0;
    big_left = 3;
    paused = 1'b0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // directed blocks
    set_format(FMT_ADAPTIVE);
    blk_bytes.delete();
    send_block(10'd1);                       // empty adaptive block
    blk_bytes = '{8'hff};
    send_block(10'd0);                       // zero count
    blk_bytes = '{8'h00};
    send_block(10'd1023);                    // count far above the block size
    blk_bytes = '{8'd38, 8'h00};
    send_block(10'(BLK));                    // bad tag, then ignored byte
    blk_bytes = '{TAG_CONST_MIN, 8'haa};
    send_block(10'd1);
    blk_bytes = '{8'h00};
    send_block(10'd1);                       // bit-packing width zero, no payload
    blk_bytes = '{TAG_PFOR, 8'h20, 8'h00, 8'h01};
    send_block(10'd2);                       // ends between position and patch
    blk_bytes = '{TAG_PFOR, 8'h21, 8'h5a, 8'h00, 8'hff};
    send_block(10'd1);
    blk_bytes = '{TAG_SVB, 8'h01, 8'hab};
    send_block(10'd1);
    wait_drained();
    set_format(FMT_FIXED);
    blk_bytes.delete();
    send_block(10'd1);                       // empty fixed block
    blk_bytes = '{8'h00};
    send_block(10'd1);
    wait_drained();
    set_format(FMT_UNKNOWN);
    blk_bytes = '{8'h24};
    send_block(10'd4);

    for (int p = 0; p < 8; p++) begin
      wait_drained();
      set_format(fmt_plan[p]);
      idle_on = (p != 3 && p != 7);
      junk_on = 1'b1;
      budget = (fmt_plan[p] == FMT_UNKNOWN) ? 60 : 140;
      sent_bytes = 0;
      if (p == 1) begin
        // result side holds off while one-byte blocks keep coming
        hold_req = 1'b1;
        repeat (40) begin
          blk_bytes = '{8'($urandom)};
          send_block(10'($urandom_range(1, 16)));
        end
        sent_bytes = 0;
      end
      while (sent_bytes < budget) begin
        send_random_block(fmt_plan[p]);
        if (p == 4 && !paused && sent_bytes > budget / 2) begin
          wait_drained();
          paused = 1'b1;
        end
      end
    end
    wait_drained();

    if (sb.verdicts.size() != 0)
      sb.flag($sformatf("%0d results never arrived", sb.verdicts.size()));
    if (sb.fails == 0) begin
      $display("posting_block_structure_check_unit_tb OK");
    end else begin
      $display("posting_block_structure_check_unit_tb NOT OK");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/pbsc_pkg.sv
rtl/core/posting_block_structure_check_unit.sv
bench/posting_block_structure_check_unit_tb.sv
